// ===== rtl/core/mfd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Motor feedback frame decoder package
// Shared types and constants of the frame decoder: register indexes, reset
// identifiers, angle scaling constants and the queue entry format.
// ----------------------------------------------------------------------------
package mfd_pkg;

	localparam int MOTOR_COUNT     = 5;
	localparam int IDX_W           = 3;
	localparam int ID_W            = 11;
	localparam int GAIN_W          = 17;
	localparam int PAYLOAD_W       = 56;
	localparam int CFG_INDEX_W     = 3;
	localparam int CFG_DATA_W      = 17;
	localparam int S_TDATA_W       = 72;
	localparam int M_TDATA_W       = 152;
	localparam int QUEUE_DEPTH_DEF = 4;

	// register indexes
	localparam logic [CFG_INDEX_W-1:0] REG_WHEEL_FL_ID = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_WHEEL_FR_ID = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_WHEEL_BR_ID = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_WHEEL_BL_ID = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_YAW_ID      = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] REG_GAIN        = 3'd5;

	localparam logic [IDX_W-1:0] YAW_INDEX = 3'd4;

	localparam logic [ID_W-1:0] ID_RESET [MOTOR_COUNT] =
		'{11'd513, 11'd514, 11'd515, 11'd516, 11'd517};
	localparam logic [GAIN_W-1:0] GAIN_RESET = 17'd3458;
	localparam logic [GAIN_W-1:0] GAIN_MAX   = 17'd65536;

	localparam logic signed [16:0] TURN_JUMP     = 17'sd5500;
	localparam logic signed [16:0] TURN_JUMP_NEG = -17'sd5500;
	localparam logic signed [15:0] TURNS_MAX     = 16'sh7FFF;
	localparam logic signed [15:0] TURNS_MIN     = 16'sh8000;

	localparam logic signed [22:0] Q10_PER_TURN      = 23'sd368640;
	localparam logic signed [22:0] Q10_HALF_TURN     = 23'sd184320;
	localparam logic signed [22:0] Q10_HALF_TURN_NEG = -23'sd184320;

	typedef struct packed {
		logic [IDX_W-1:0]     idx;
		logic [PAYLOAD_W-1:0] payload;
	} mfd_entry_t;

	typedef struct packed {
		logic       valid;
		mfd_entry_t entry;
	} mfd_push_t;

	typedef struct packed {
		logic       valid;
		mfd_entry_t entry;
	} mfd_head_t;

endpackage

`default_nettype wire

// ===== rtl/core/motor_feedback_frame_decoder.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Motor feedback frame decoder
// Decodes motor feedback frames into angle, speed, current, temperature and,
// for the yaw motor, turn count with continuous and folded angles.
// ----------------------------------------------------------------------------
// Takes one frame per clock and gives at most one result per frame, in frame
// order. Frames that are not from the primary bus or whose identifier matches
// no configured motor are taken and dropped. A matched frame appears on the
// output after passing through the queue and the first back stage, after
// which the output register holds it. The first back stage updates the yaw
// turn counter as each frame is popped and so keeps the rate of one frame per
// cycle while the output is not stalled. The queue of QUEUE_DEPTH entries
// absorbs output stalls; once it is full the input stalls. Write the
// identifier and gain registers only while no frame is in flight.
// ----------------------------------------------------------------------------
module motor_feedback_frame_decoder #(
	parameter int QUEUE_DEPTH = mfd_pkg::QUEUE_DEPTH_DEF
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_we,
	input  wire logic [mfd_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  wire logic [mfd_pkg::CFG_DATA_W-1:0]   cfg_wdata,
	input  wire logic                             s_tvalid,
	output logic                                  s_tready,
	// frame_id [10:0], payload [66:11], zero [71:67]
	input  wire logic [mfd_pkg::S_TDATA_W-1:0]    s_tdata,
	// bus_is_primary [0]
	input  wire logic [0:0]                       s_tuser,
	output logic                                  m_tvalid,
	input  wire logic                             m_tready,
	// raw_angle [15:0], speed_q16 [47:16], motor_current [63:48],
	// temperature [71:64], turn_count [87:72], continuous_angle_q10 [122:88],
	// wrapped_angle_q10 [144:123], zero [151:145]
	output logic [mfd_pkg::M_TDATA_W-1:0]         m_tdata,
	// motor_index [2:0]
	output logic [mfd_pkg::IDX_W-1:0]             m_tuser
);

	mfd_pkg::mfd_push_t          push;
	mfd_pkg::mfd_head_t          head;
	logic                        q_full;
	logic                        pop;
	logic [mfd_pkg::GAIN_W-1:0]  gain;

	mfd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.q_full    (q_full),
		.push      (push),
		.gain      (gain)
	);

	mfd_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (q_full),
		.head   (head),
		.pop    (pop)
	);

	mfd_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (head),
		.pop      (pop),
		.gain     (gain),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

endmodule

`default_nettype wire

// ===== rtl/core/mfd_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Frame decoder front end
// Holds the identifier and gain registers, accepts frames and pushes the
// ones that belong to a configured motor into the queue with their index.
// ----------------------------------------------------------------------------
module mfd_front (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_we,
	input  wire logic [mfd_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  wire logic [mfd_pkg::CFG_DATA_W-1:0]   cfg_wdata,
	input  wire logic                             s_tvalid,
	output logic                                  s_tready,
	input  wire logic [mfd_pkg::S_TDATA_W-1:0]    s_tdata,
	input  wire logic [0:0]                       s_tuser,
	input  wire logic                             q_full,
	output mfd_pkg::mfd_push_t                    push,
	output logic [mfd_pkg::GAIN_W-1:0]            gain
);

	logic [mfd_pkg::ID_W-1:0]   ids_q [mfd_pkg::MOTOR_COUNT];
	logic [mfd_pkg::GAIN_W-1:0] gain_q;
	logic [mfd_pkg::ID_W-1:0]   frame_id;
	logic                       hit;
	logic [mfd_pkg::IDX_W-1:0]  idx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < mfd_pkg::MOTOR_COUNT; i++) begin
				ids_q[i] <= mfd_pkg::ID_RESET[i];
			end
			gain_q <= mfd_pkg::GAIN_RESET;
		end else if (cfg_we) begin
			if (cfg_index <= mfd_pkg::REG_YAW_ID) begin
				ids_q[cfg_index] <= cfg_wdata[mfd_pkg::ID_W-1:0];
			end else if (cfg_index == mfd_pkg::REG_GAIN) begin
				gain_q <= cfg_wdata[mfd_pkg::GAIN_W-1:0];
			end
		end
	end

	assign gain = (gain_q > mfd_pkg::GAIN_MAX) ? mfd_pkg::GAIN_MAX : gain_q;

	assign frame_id = s_tdata[mfd_pkg::ID_W-1:0];

	// scan downward so the lowest matching index wins
	always_comb begin
		hit = 1'b0;
		idx = '0;
		for (int i = mfd_pkg::MOTOR_COUNT - 1; i >= 0; i--) begin
			if (ids_q[i] == frame_id) begin
				hit = 1'b1;
				idx = mfd_pkg::IDX_W'(i);
			end
		end
	end

	assign s_tready = !q_full;

	always_comb begin
		push.valid         = s_tvalid && s_tready && s_tuser[0] && hit;
		push.entry.idx     = idx;
		push.entry.payload = s_tdata[mfd_pkg::ID_W +: mfd_pkg::PAYLOAD_W];
	end

endmodule

`default_nettype wire

// ===== rtl/core/mfd_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Frame decoder queue
// Short first-in first-out buffer of matched frames between front and back.
// ----------------------------------------------------------------------------
module mfd_queue #(
	parameter int DEPTH = mfd_pkg::QUEUE_DEPTH_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire mfd_pkg::mfd_push_t push,
	output logic                    full,
	output mfd_pkg::mfd_head_t      head,
	input  wire logic               pop
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	mfd_pkg::mfd_entry_t mem_q [DEPTH];
	logic [PTR_W-1:0]    wr_ptr_q;
	logic [PTR_W-1:0]    rd_ptr_q;
	logic [CNT_W-1:0]    count_q;
	logic                do_push;
	logic                do_pop;

	assign full    = (count_q == CNT_W'(DEPTH));
	assign do_push = push.valid && !full;
	assign do_pop  = pop && (count_q != '0);

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push.entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_comb begin
		head.valid = (count_q != '0);
		head.entry = mem_q[rd_ptr_q];
	end

endmodule

`default_nettype wire

// ===== rtl/core/mfd_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Frame decoder back end
// Two-stage pipeline: stage one splits the payload, scales the speed and
// tracks yaw turns; stage two forms the continuous and folded angles and
// holds the result for the output stream.
// ----------------------------------------------------------------------------
module mfd_back (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire mfd_pkg::mfd_head_t             head,
	output logic                                pop,
	input  wire logic [mfd_pkg::GAIN_W-1:0]     gain,
	output logic                                m_tvalid,
	input  wire logic                           m_tready,
	output logic [mfd_pkg::M_TDATA_W-1:0]       m_tdata,
	output logic [mfd_pkg::IDX_W-1:0]           m_tuser
);

	// yaw tracking state
	logic signed [15:0] yaw_prev_q;
	logic signed [15:0] yaw_turns_q;

	// stage one
	logic                       valid_s1;
	logic [mfd_pkg::IDX_W-1:0]  idx_s1;
	logic signed [15:0]         angle_s1;
	logic [31:0]                speed_s1;
	logic [15:0]                current_s1;
	logic [7:0]                 temp_s1;
	logic signed [15:0]         turns_s1;
	logic signed [21:0]         ang45_s1;

	// stage two (output register)
	logic                       valid_s2;
	logic [mfd_pkg::IDX_W-1:0]  idx_s2;
	logic [15:0]                angle_s2;
	logic [31:0]                speed_s2;
	logic [15:0]                current_s2;
	logic [7:0]                 temp_s2;
	logic [15:0]                turns_s2;
	logic [34:0]                cont_s2;
	logic [21:0]                wrapped_s2;

	logic               s2_ready;
	logic               s1_ready;
	logic               is_yaw;
	logic signed [15:0] angle;
	logic signed [15:0] speed_raw;
	logic signed [16:0] diff;
	logic signed [15:0] turns_next;
	logic signed [17:0] gain_s;
	logic signed [33:0] prod;
	logic signed [21:0] angle_ext;
	logic signed [21:0] ang45;
	logic               yaw_s1;
	logic signed [21:0] turns_ext;
	logic signed [21:0] turns45;
	logic signed [34:0] cont;
	logic signed [22:0] w_ext;
	logic signed [22:0] w_fold;

	assign s2_ready = !valid_s2 || m_tready;
	assign s1_ready = !valid_s1 || s2_ready;
	assign pop      = head.valid && s1_ready;

	assign is_yaw    = (head.entry.idx == mfd_pkg::YAW_INDEX);
	assign angle     = $signed(head.entry.payload[55:40]);
	assign speed_raw = $signed(head.entry.payload[39:24]);
	assign diff      = $signed({angle[15], angle}) - $signed({yaw_prev_q[15], yaw_prev_q});

	// a large backward jump means the angle wrapped forward, and the reverse
	always_comb begin
		turns_next = yaw_turns_q;
		if (diff < mfd_pkg::TURN_JUMP_NEG) begin
			if (yaw_turns_q != mfd_pkg::TURNS_MAX) begin
				turns_next = yaw_turns_q + 16'sd1;
			end
		end else if (diff > mfd_pkg::TURN_JUMP) begin
			if (yaw_turns_q != mfd_pkg::TURNS_MIN) begin
				turns_next = yaw_turns_q - 16'sd1;
			end
		end
	end

	assign gain_s    = $signed({1'b0, gain});
	assign prod      = speed_raw * gain_s;
	assign angle_ext = $signed({{6{angle[15]}}, angle});
	// times 45 = 32 + 8 + 4 + 1
	assign ang45     = (angle_ext <<< 5) + (angle_ext <<< 3) + (angle_ext <<< 2) + angle_ext;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			yaw_prev_q  <= '0;
			yaw_turns_q <= '0;
		end else if (pop && is_yaw) begin
			yaw_prev_q  <= angle;
			yaw_turns_q <= turns_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s1_ready) begin
			valid_s1 <= head.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			idx_s1     <= head.entry.idx;
			angle_s1   <= angle;
			speed_s1   <= is_yaw ? {speed_raw, 16'h0000} : prod[31:0];
			current_s1 <= head.entry.payload[23:8];
			temp_s1    <= head.entry.payload[7:0];
			turns_s1   <= is_yaw ? turns_next : 16'sd0;
			ang45_s1   <= ang45;
		end
	end

	assign yaw_s1    = (idx_s1 == mfd_pkg::YAW_INDEX);
	assign turns_ext = $signed({{6{turns_s1[15]}}, turns_s1});
	assign turns45   = (turns_ext <<< 5) + (turns_ext <<< 3) + (turns_ext <<< 2) + turns_ext;
	// one turn is 45 * 8192 in Q10 degrees
	assign cont      = $signed({turns45, 13'd0}) + $signed({{13{ang45_s1[21]}}, ang45_s1});
	assign w_ext     = $signed({ang45_s1[21], ang45_s1});

	always_comb begin
		w_fold = w_ext;
		if (yaw_s1) begin
			if (w_ext < mfd_pkg::Q10_HALF_TURN_NEG) begin
				w_fold = w_ext + mfd_pkg::Q10_PER_TURN;
			end else if (w_ext > mfd_pkg::Q10_HALF_TURN) begin
				w_fold = w_ext - mfd_pkg::Q10_PER_TURN;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_ready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_ready && valid_s1) begin
			idx_s2     <= idx_s1;
			angle_s2   <= angle_s1;
			speed_s2   <= speed_s1;
			current_s2 <= current_s1;
			temp_s2    <= temp_s1;
			turns_s2   <= turns_s1;
			cont_s2    <= yaw_s1 ? cont : 35'd0;
			wrapped_s2 <= w_fold[21:0];
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tuser  = idx_s2;
	assign m_tdata  = {7'd0, wrapped_s2, cont_s2, turns_s2, temp_s2, current_s2,
		speed_s2, angle_s2};

endmodule

`default_nettype wire

// ===== tb/sv/feedback_decode_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Feedback decode checker
// Watches the register port and both streams of the frame decoder. It keeps
// its own copy of the motor identifiers, the wheel gain and the yaw turn
// state, decodes each accepted frame, and compares every result field by
// field with the oldest decoded frame still waiting.
// ----------------------------------------------------------------------------
module feedback_decode_checker
	import mfd_pkg::*;
(
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   cfg_we,
	input  wire logic [CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [CFG_DATA_W-1:0]  cfg_wdata,
	input  wire logic                   s_tvalid,
	input  wire logic                   s_tready,
	input  wire logic [S_TDATA_W-1:0]   s_tdata,
	input  wire logic [0:0]             s_tuser,
	input  wire logic                   m_tvalid,
	input  wire logic                   m_tready,
	input  wire logic [M_TDATA_W-1:0]   m_tdata,
	input  wire logic [IDX_W-1:0]       m_tuser,
	output int                          mismatches,
	output int                          pending
);

	localparam int    JUMP_COUNTS   = 5500;
	localparam longint Q10_TURN     = 368640;
	localparam longint Q10_HALF     = 184320;
	localparam longint Q10_PER_STEP = 45;
	localparam int    REPORT_MAX    = 10;

	typedef struct packed {
		logic [IDX_W-1:0] motor_index;
		logic [15:0]      raw_angle;
		logic [31:0]      speed_q16;
		logic [15:0]      motor_current;
		logic [7:0]       temperature;
		logic [15:0]      turn_count;
		logic [34:0]      continuous_angle;
		logic [21:0]      wrapped_angle;
	} feedback_t;

	logic [ID_W-1:0]      motor_id [MOTOR_COUNT];
	logic [GAIN_W-1:0]    wheel_gain;
	logic signed [15:0]   yaw_prev;
	logic signed [15:0]   yaw_turns;
	feedback_t            expected_feedback [$];
	int                   err_count;

	// Decode one frame; returns 1 when it yields a result.
	function automatic bit decode_frame(input logic primary, input logic [ID_W-1:0] id,
			input logic [PAYLOAD_W-1:0] pl, output feedback_t res);
		int                 hit;
		int                 diff;
		logic signed [15:0] ang;
		logic signed [15:0] spd;
		logic signed [15:0] cur;
		logic signed [15:0] turns;
		logic [GAIN_W-1:0]  g;
		longint             speed;
		longint             cont;
		longint             wrapped;
		hit = -1;
		res = '0;
		for (int i = 0; i < MOTOR_COUNT; i++)
			if (hit < 0 && motor_id[i] == id)
				hit = i;
		if (!primary || hit < 0)
			return 1'b0;
		ang = pl[55:40];
		spd = pl[39:24];
		cur = pl[23:8];
		wrapped = longint'(ang) * Q10_PER_STEP;
		turns = '0;
		cont = 0;
		if (hit != int'(YAW_INDEX)) begin
			g = (wheel_gain > GAIN_MAX) ? GAIN_MAX : wheel_gain;
			speed = longint'(spd) * longint'({15'd0, g});
		end else begin
			diff = int'(ang) - int'(yaw_prev);
			speed = longint'(spd) * 65536;
			if (diff < -JUMP_COUNTS) begin
				if (yaw_turns != TURNS_MAX)
					yaw_turns = yaw_turns + 16'sd1;
			end else if (diff > JUMP_COUNTS) begin
				if (yaw_turns != TURNS_MIN)
					yaw_turns = yaw_turns - 16'sd1;
			end
			yaw_prev = ang;
			turns = yaw_turns;
			cont = longint'(turns) * Q10_TURN + wrapped;
			// fold once into half a turn either side
			if (wrapped < -Q10_HALF)
				wrapped = wrapped + Q10_TURN;
			else if (wrapped > Q10_HALF)
				wrapped = wrapped - Q10_TURN;
		end
		res.motor_index      = IDX_W'(hit);
		res.raw_angle        = ang;
		res.speed_q16        = speed[31:0];
		res.motor_current    = cur;
		res.temperature      = pl[7:0];
		res.turn_count       = turns;
		res.continuous_angle = cont[34:0];
		res.wrapped_angle    = wrapped[21:0];
		return 1'b1;
	endfunction

	task automatic check_field(input string label, input logic [63:0] want,
			input logic [63:0] got);
		if (want !== got) begin
			if (err_count < REPORT_MAX)
				$display("mismatch %s: expected %0h, got %0h", label, want, got);
			err_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		feedback_t got;
		feedback_t want;
		feedback_t res;
		if (!arst_n) begin
			for (int i = 0; i < MOTOR_COUNT; i++)
				motor_id[i] = ID_RESET[i];
			wheel_gain = GAIN_RESET;
			yaw_prev = '0;
			yaw_turns = '0;
			expected_feedback.delete();
			err_count = 0;
			pending <= 0;
			mismatches <= 0;
		end else begin
			if (cfg_we) begin
				if (cfg_index < CFG_INDEX_W'(MOTOR_COUNT))
					motor_id[cfg_index] = cfg_wdata[ID_W-1:0];
				else if (cfg_index == REG_GAIN)
					wheel_gain = cfg_wdata[GAIN_W-1:0];
			end
			if (m_tvalid && m_tready) begin
				got.motor_index      = m_tuser;
				got.raw_angle        = m_tdata[15:0];
				got.speed_q16        = m_tdata[47:16];
				got.motor_current    = m_tdata[63:48];
				got.temperature      = m_tdata[71:64];
				got.turn_count       = m_tdata[87:72];
				got.continuous_angle = m_tdata[122:88];
				got.wrapped_angle    = m_tdata[144:123];
				if (expected_feedback.size() == 0) begin
					if (err_count < REPORT_MAX)
						$display("unexpected result: motor %0d angle %0h",
							got.motor_index, got.raw_angle);
					err_count++;
				end else begin
					want = expected_feedback.pop_front();
					check_field("motor_index", 64'(want.motor_index), 64'(got.motor_index));
					check_field("raw_angle", 64'(want.raw_angle), 64'(got.raw_angle));
					check_field("speed_q16", 64'(want.speed_q16), 64'(got.speed_q16));
					check_field("motor_current", 64'(want.motor_current),
						64'(got.motor_current));
					check_field("temperature", 64'(want.temperature), 64'(got.temperature));
					check_field("turn_count", 64'(want.turn_count), 64'(got.turn_count));
					check_field("continuous_angle_q10", 64'(want.continuous_angle),
						64'(got.continuous_angle));
					check_field("wrapped_angle_q10", 64'(want.wrapped_angle),
						64'(got.wrapped_angle));
				end
			end
			if (s_tvalid && s_tready) begin
				if (decode_frame(s_tuser[0], s_tdata[ID_W-1:0],
						s_tdata[ID_W+PAYLOAD_W-1:ID_W], res))
					expected_feedback.push_back(res);
			end
			pending <= expected_feedback.size();
			mismatches <= err_count;
		end
	end

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Motor feedback frame decoder testbench
// Drives feedback frames through the decoder under several identifier and
// gain settings: a directed set of edge frames, random traffic with idle gaps
// on both streams, and yaw sweeps that count turns upward and back down
// through zero. The checker beside the decoder predicts and compares.
// ----------------------------------------------------------------------------
module tb;
	import mfd_pkg::*;

	localparam int CYCLE_LIMIT   = 1_500_000;
	localparam int SETTLE_CYCLES = 16;
	localparam int PHASE_FRAMES  = 150;
	localparam logic [CFG_INDEX_W-1:0] REG_SPARE_A = 3'd6;
	localparam logic [CFG_INDEX_W-1:0] REG_SPARE_B = 3'd7;

	logic                   clk       = 1'b0;
	logic                   arst_n    = 1'b0;
	logic                   cfg_we    = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_wdata = '0;
	logic                   s_tvalid  = 1'b0;
	logic [S_TDATA_W-1:0]   s_tdata   = '0;
	logic [0:0]             s_tuser   = '0;
	logic                   m_tready  = 1'b0;
	wire logic              s_tready;
	wire logic              m_tvalid;
	wire logic [M_TDATA_W-1:0] m_tdata;
	wire logic [IDX_W-1:0]  m_tuser;

	int              fail_count;
	int              pending;
	int              cycle_count = 0;
	bit              rush        = 1'b0;
	int              calm_left   = 0;
	int              ready_stall = 0;
	int              ready_open  = 0;
	int              ready_roll;
	int              yaw_last    = 0;
	logic [ID_W-1:0] cur_id [MOTOR_COUNT];

	always #4 clk = ~clk;

	motor_feedback_frame_decoder dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

	feedback_decode_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser),
		.mismatches (fail_count),
		.pending    (pending)
	);

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// Output back-pressure: short stalls mostly, a few long ones, open stretches.
	always @(posedge clk) begin
		if (rush || !arst_n) begin
			m_tready <= arst_n;
		end else if (ready_stall > 0) begin
			ready_stall--;
			m_tready <= 1'b0;
		end else if (ready_open > 0) begin
			ready_open--;
			m_tready <= 1'b1;
		end else begin
			ready_roll = $urandom_range(0, 99);
			if (ready_roll < 8)
				ready_open = $urandom_range(20, 80);
			else if (ready_roll < 30)
				ready_stall = $urandom_range(0, 2);
			else if (ready_roll < 34)
				ready_stall = $urandom_range(6, 40);
			m_tready <= (ready_roll < 8 || ready_roll >= 34);
		end
	end

	function automatic int pick_gap();
		int r;
		if (rush)
			return 0;
		if (calm_left > 0) begin
			calm_left--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 5) begin
			calm_left = $urandom_range(15, 60);
			return 0;
		end
		if (r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(6, 30);
	endfunction

	function automatic logic [PAYLOAD_W-1:0] make_payload(input logic [15:0] ang,
			input logic [15:0] spd, input logic [15:0] cur, input logic [7:0] temp);
		return {ang, spd, cur, temp};
	endfunction

	// Random walk of the yaw angle with small steps, turn jumps and wild values.
	function automatic int next_yaw(input int last);
		int k;
		int step;
		int nxt;
		k = $urandom_range(0, 99);
		if (k < 6)
			step = (k < 3) ? 5500 : 5501;
		else if (k < 50)
			step = $urandom_range(0, 5500);
		else if (k < 80)
			step = $urandom_range(5501, 12000);
		else
			return int'($urandom_range(0, 65535)) - 32768;
		if ($urandom_range(0, 1))
			step = -step;
		nxt = last + step;
		if (nxt > 32767 || nxt < -32768)
			nxt = last - step;
		return nxt;
	endfunction

	// Called right after a rising edge; returns at the edge that takes the request.
	task automatic send_frame(input bit primary, input logic [ID_W-1:0] id,
			input logic [PAYLOAD_W-1:0] pl);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {{(S_TDATA_W-ID_W-PAYLOAD_W){1'b0}}, pl, id};
		s_tuser  <= primary;
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic drain_and_settle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(posedge clk);
	endtask

	task automatic program_regs(input logic [CFG_DATA_W-1:0] w0, w1, w2, w3, w4,
			input logic [CFG_DATA_W-1:0] gain);
		write_reg(REG_WHEEL_FL_ID, w0);
		write_reg(REG_WHEEL_FR_ID, w1);
		write_reg(REG_WHEEL_BR_ID, w2);
		write_reg(REG_WHEEL_BL_ID, w3);
		write_reg(REG_YAW_ID, w4);
		write_reg(REG_GAIN, gain);
		cfg_we <= 1'b0;
		@(posedge clk);
		cur_id[0] = w0[ID_W-1:0];
		cur_id[1] = w1[ID_W-1:0];
		cur_id[2] = w2[ID_W-1:0];
		cur_id[3] = w3[ID_W-1:0];
		cur_id[4] = w4[ID_W-1:0];
	endtask

	task automatic random_phase(input int count);
		int                   r;
		int                   pick;
		bit                   primary;
		logic [ID_W-1:0]      id;
		logic [PAYLOAD_W-1:0] pl;
		for (int n = 0; n < count; n++) begin
			pl = PAYLOAD_W'({$urandom, $urandom});
			r = $urandom_range(0, 99);
			pick = $urandom_range(0, 9);
			pick = (pick < 4) ? int'(YAW_INDEX) : (pick - 4) % 4;
			id = cur_id[pick];
			primary = 1'b1;
			if (r < 7)
				primary = 1'b0;
			else if (r < 14)
				id = ID_W'($urandom);
			else if (r < 20)
				pl[39:24] = r[0] ? 16'h7FFF : 16'h8000;
			if (pick == int'(YAW_INDEX) && primary) begin
				yaw_last = next_yaw(yaw_last);
				pl[55:40] = 16'(yaw_last);
			end
			send_frame(primary, id, pl);
		end
	endtask

	// Sweep the yaw angle so each counting step moves the turn counter one way:
	// jumps beyond the threshold in one direction, returns within it the other.
	task automatic turn_sweep(input bit upward, input int turns_wanted);
		int done;
		int cur;
		int nxt;
		int sgn;
		int jump;
		int back;
		bit counting;
		done = 0;
		cur = 0;
		counting = 1'b1;
		sgn = upward ? -1 : 1;
		send_frame(1'b1, cur_id[4], make_payload(16'd0, 16'($urandom), 16'($urandom),
			8'($urandom)));
		while (done < turns_wanted) begin
			jump = $urandom_range(5501, 8000);
			back = $urandom_range(4000, 5500);
			nxt = counting ? cur + sgn * jump : cur - sgn * back;
			if (nxt < -32768 || nxt > 32767) begin
				counting = !counting;
				nxt = counting ? cur + sgn * jump : cur - sgn * back;
			end
			if (counting)
				done++;
			cur = nxt;
			send_frame(1'b1, cur_id[4], make_payload(16'(cur), 16'($urandom),
				16'($urandom), 8'($urandom)));
		end
		yaw_last = cur;
	endtask

	initial begin
		logic [CFG_DATA_W-1:0] shared;
		for (int i = 0; i < MOTOR_COUNT; i++)
			cur_id[i] = ID_RESET[i];
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: turn threshold edges, fold edges, field extremes, drops
		send_frame(1'b1, cur_id[4], make_payload(16'd0, 16'h7FFF, 16'h0000, 8'h00));
		send_frame(1'b1, cur_id[4], make_payload(16'd5500, 16'h8000, 16'hFFFF, 8'hFF));
		send_frame(1'b1, cur_id[4], make_payload(16'd0, 16'h0001, 16'h7FFF, 8'h01));
		send_frame(1'b1, cur_id[4], make_payload(16'(-5501), 16'hFFFF, 16'h8000, 8'h80));
		send_frame(1'b1, cur_id[4], make_payload(16'd0, 16'h0000, 16'h0001, 8'h7F));
		send_frame(1'b1, cur_id[4], make_payload(16'h7FFF, 16'h1234, 16'h4321, 8'h55));
		send_frame(1'b1, cur_id[4], make_payload(16'h8000, 16'hABCD, 16'hDCBA, 8'hAA));
		send_frame(1'b1, cur_id[4], make_payload(16'd4096, 16'h0100, 16'h0200, 8'h10));
		send_frame(1'b1, cur_id[4], make_payload(16'(-4096), 16'h0300, 16'h0400, 8'h20));
		send_frame(1'b1, cur_id[4], make_payload(16'd4097, 16'h0500, 16'h0600, 8'h30));
		send_frame(1'b1, cur_id[4], make_payload(16'(-4097), 16'h0700, 16'h0800, 8'h40));
		send_frame(1'b1, cur_id[0], {PAYLOAD_W{1'b1}});
		send_frame(1'b1, cur_id[1], make_payload(16'h7FFF, 16'h7FFF, 16'h7FFF, 8'hFF));
		send_frame(1'b1, cur_id[2], make_payload(16'h8000, 16'h8000, 16'h8000, 8'h00));
		send_frame(1'b1, cur_id[3], PAYLOAD_W'({$urandom, $urandom}));
		send_frame(1'b0, cur_id[4], PAYLOAD_W'({$urandom, $urandom}));
		send_frame(1'b1, 11'd0, PAYLOAD_W'({$urandom, $urandom}));
		send_frame(1'b1, 11'h7FF, PAYLOAD_W'({$urandom, $urandom}));
		send_frame(1'b0, 11'h7FF, {PAYLOAD_W{1'b1}});
		yaw_last = -4097;

		// zero gain, random identifiers
		drain_and_settle();
		program_regs(17'($urandom), 17'($urandom), 17'($urandom), 17'($urandom),
			17'($urandom), 17'd0);
		random_phase(PHASE_FRAMES);

		// extreme identifiers; yaw shares its id with a wheel, so the wheel wins
		drain_and_settle();
		program_regs(17'd0, 17'h7FF, 17'($urandom), 17'($urandom), 17'h7FF, GAIN_MAX);
		random_phase(PHASE_FRAMES);

		// every motor on one id, gain far above the saturation point
		drain_and_settle();
		shared = 17'($urandom);
		program_regs(shared, shared, shared, shared, shared, 17'h1FFFF);
		random_phase(PHASE_FRAMES);

		// spare indexes must be ignored; junk above the id width must be dropped
		drain_and_settle();
		write_reg(REG_SPARE_A, 17'($urandom));
		write_reg(REG_SPARE_B, 17'($urandom));
		program_regs(17'($urandom), 17'($urandom), 17'($urandom), 17'($urandom),
			17'($urandom), 17'($urandom));
		random_phase(PHASE_FRAMES);

		drain_and_settle();
		program_regs(17'($urandom), 17'($urandom), 17'($urandom), 17'($urandom),
			17'd0, 17'hFFFF);
		random_phase(PHASE_FRAMES);

		// count turns upward, then back down through zero
		drain_and_settle();
		program_regs({6'd0, ID_RESET[0]}, {6'd0, ID_RESET[1]}, {6'd0, ID_RESET[2]},
			{6'd0, ID_RESET[3]}, {6'd0, ID_RESET[4]}, GAIN_RESET);
		rush = 1'b1;
		turn_sweep(1'b1, 12);
		turn_sweep(1'b0, 24);
		rush = 1'b0;
		random_phase(60);

		drain_and_settle();
		if (fail_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
